FILE: src/hiqp_pkg.sv
package hiqp_pkg;

	localparam int KEY_W    = 31;
	localparam int WORD_W   = 32;
	localparam int SLOT_W   = 8;
	localparam int PROBES_W = 12;
	localparam int FRAC_W   = 16;
	localparam int COEFF_W  = 20;
	localparam int SHIFT_W  = 5;
	localparam int CIDX_W   = 8;

	localparam logic [CIDX_W-1:0] CFG_HASH_MULT  = 8'd0;
	localparam logic [CIDX_W-1:0] CFG_HASH_SHIFT = 8'd1;
	localparam logic [CIDX_W-1:0] CFG_LIN_COEFF  = 8'd2;
	localparam logic [CIDX_W-1:0] CFG_QUAD_COEFF = 8'd3;

	localparam logic [WORD_W-1:0]  RST_HASH_MULT  = 32'd2654435769;
	localparam logic [SHIFT_W-1:0] RST_HASH_SHIFT = 5'd4;
	localparam logic [COEFF_W-1:0] RST_LIN_COEFF  = 20'd131203;
	localparam logic [COEFF_W-1:0] RST_QUAD_COEFF = 20'd131858;

	localparam logic [WORD_W-1:0]   EMPTY_WORD = '1;
	localparam logic [PROBES_W-1:0] PROBES_SAT = '1;

	typedef struct packed {
		logic [WORD_W-1:0]  hash_multiplier;
		logic [SHIFT_W-1:0] hash_shift;
		logic [COEFF_W-1:0] linear_coeff;
		logic [COEFF_W-1:0] quadratic_coeff;
	} cfg_t;

	typedef enum logic [2:0] {
		F_IDLE,
		F_MUL,
		F_SHIFT,
		F_DIV,
		F_PUSH
	} front_state_t;

	typedef enum logic [1:0] {
		B_CLEAR,
		B_IDLE,
		B_READ,
		B_CHECK
	} back_state_t;

endpackage

FILE: src/hiqp_ram.sv
module hiqp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: src/hiqp_fifo.sv
module hiqp_fifo #(
	parameter int WIDTH = 39,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	logic [WIDTH-1:0] buf_q [DEPTH];
	logic [PW-1:0]    wr_q;
	logic [PW-1:0]    rd_q;
	logic [CW-1:0]    cnt_q;

	assign full  = (cnt_q == CNT_FULL);
	assign empty = (cnt_q == '0);
	assign rdata = buf_q[rd_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			buf_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full) begin
				wr_q <= (wr_q == PTR_LAST) ? '0 : wr_q + PW'(1);
			end
			if (pop && !empty) begin
				rd_q <= (rd_q == PTR_LAST) ? '0 : rd_q + PW'(1);
			end
			unique case ({push && !full, pop && !empty})
				2'b10:   cnt_q <= cnt_q + CW'(1);
				2'b01:   cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

FILE: src/hiqp_front.sv
module hiqp_front import hiqp_pkg::*; #(
	parameter int SLOTS = 256
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cfg_t                     cfg,
	input  logic                     clearing,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [KEY_W-1:0]         key,
	output logic                     push,
	input  logic                     q_full,
	output logic [KEY_W-1:0]         push_key,
	output logic [$clog2(SLOTS)-1:0] push_home
);

	localparam int SW        = $clog2(SLOTS);
	localparam int DIV_STEPS = 4;
	localparam int DIV_BITS  = WORD_W / DIV_STEPS;
	localparam logic [SW:0] SLOTS_W  = (SW + 1)'(SLOTS);
	localparam logic [1:0]  STEP_END = 2'(DIV_STEPS - 1);

	front_state_t state_q, state_d;

	logic [KEY_W-1:0]  key_q;
	logic [WORD_W-1:0] prod_q;
	logic [WORD_W-1:0] dv_q;
	logic [SW-1:0]     rem_q;
	logic [1:0]        stp_q;

	logic [SW-1:0]     rem_nx;
	logic [WORD_W-1:0] dv_nx;

	// restoring remainder, DIV_BITS dividend bits per cycle, MSB first
	always_comb begin
		logic [SW:0]       t;
		logic [SW-1:0]     r;
		logic [WORD_W-1:0] d;
		r = rem_q;
		d = dv_q;
		for (int k = 0; k < DIV_BITS; k++) begin
			t = {r, d[WORD_W-1]};
			if (t >= SLOTS_W) begin
				t = t - SLOTS_W;
			end
			r = t[SW-1:0];
			d = {d[WORD_W-2:0], 1'b0};
		end
		rem_nx = r;
		dv_nx  = d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		push     = 1'b0;
		unique case (state_q)
			F_IDLE: begin
				in_ready = !clearing;
				if (in_valid && !clearing) begin
					state_d = F_MUL;
				end
			end
			F_MUL:   state_d = F_SHIFT;
			F_SHIFT: state_d = F_DIV;
			F_DIV: begin
				if (stp_q == STEP_END) begin
					state_d = F_PUSH;
				end
			end
			F_PUSH: begin
				push = !q_full;
				if (!q_full) begin
					state_d = F_IDLE;
				end
			end
			default: state_d = F_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			key_q <= key;
		end
		if (state_q == F_MUL) begin
			prod_q <= WORD_W'(cfg.hash_multiplier * {1'b0, key_q});
		end
		if (state_q == F_SHIFT) begin
			dv_q  <= prod_q >> cfg.hash_shift;
			rem_q <= '0;
			stp_q <= '0;
		end
		if (state_q == F_DIV) begin
			dv_q  <= dv_nx;
			rem_q <= rem_nx;
			stp_q <= stp_q + 2'd1;
		end
	end

	assign push_key  = key_q;
	assign push_home = rem_q;

endmodule

FILE: src/hiqp_back.sv
module hiqp_back import hiqp_pkg::*; #(
	parameter int SLOTS      = 256,
	parameter int MAX_PROBES = 2560
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cfg_t                     cfg,
	output logic                     clearing,
	input  logic                     q_empty,
	output logic                     pop,
	input  logic [KEY_W-1:0]         pop_key,
	input  logic [$clog2(SLOTS)-1:0] pop_home,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic                     inserted,
	output logic [SLOT_W-1:0]        slot,
	output logic [PROBES_W-1:0]      probes_used
);

	localparam int SW = $clog2(SLOTS);
	localparam int CW = $clog2(MAX_PROBES + 1);
	localparam logic [SW:0]    SLOTS_W    = (SW + 1)'(SLOTS);
	localparam logic [SW-1:0]  SLOT_LAST  = SW'(SLOTS - 1);
	localparam logic [CW-1:0]  PROBE_LAST = CW'(MAX_PROBES - 1);

	back_state_t state_q, state_d;

	logic [SW-1:0]     clr_q;
	logic [KEY_W-1:0]  key_q;
	logic [SW-1:0]     pos_q;
	logic [FRAC_W-1:0] ffrac_q;
	logic [SW-1:0]     dint_q;
	logic [FRAC_W-1:0] dfrac_q;
	logic [SW-1:0]     qint_q;
	logic [FRAC_W-1:0] qfrac_q;
	logic [CW-1:0]     cnt_q;

	logic                  out_valid_q;
	logic                  inserted_q;
	logic [SLOT_W-1:0]     slot_q;
	logic [PROBES_W-1:0]   probes_q;

	logic              ram_we, ram_re;
	logic [SW-1:0]     ram_addr;
	logic [WORD_W-1:0] ram_wdata, ram_rdata;

	logic                empty_hit, last_probe, finish, out_free, advance, start;
	logic [FRAC_W:0]     fsum, dsum;
	logic [SW-1:0]       pos_nx, dint_nx;
	logic [COEFF_W:0]    d0, q2;
	logic [CW:0]         used_w;
	logic [CW+PROBES_W:0] used_x;
	logic [SW+SLOT_W-1:0] pos_x;

	// (a + b + c) mod SLOTS with a, b already reduced
	function automatic logic [SW-1:0] mod_add(logic [SW-1:0] a, logic [SW-1:0] b, logic c);
		logic [SW:0] s;
		s = {1'b0, a} + {1'b0, b} + {{SW{1'b0}}, c};
		if (s >= SLOTS_W) begin
			s = s - SLOTS_W;
		end
		return s[SW-1:0];
	endfunction

	// small integer part (at most 31) reduced mod SLOTS
	function automatic logic [SW-1:0] mod_small(logic [SHIFT_W-1:0] x);
		logic [SW:0]   t;
		logic [SW-1:0] r;
		r = '0;
		for (int k = SHIFT_W - 1; k >= 0; k--) begin
			t = {r, x[k]};
			if (t >= SLOTS_W) begin
				t = t - SLOTS_W;
			end
			r = t[SW-1:0];
		end
		return r;
	endfunction

	hiqp_ram #(
		.WIDTH(WORD_W),
		.DEPTH(SLOTS)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.re   (ram_re),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	assign empty_hit  = ram_rdata[WORD_W-1];
	assign last_probe = (cnt_q == PROBE_LAST);
	assign finish     = empty_hit || last_probe;
	assign out_free   = !out_valid_q || out_ready;

	// exact running offset: position integer part kept mod SLOTS, step grows by 2*Q
	assign fsum    = {1'b0, ffrac_q} + {1'b0, dfrac_q};
	assign dsum    = {1'b0, dfrac_q} + {1'b0, qfrac_q};
	assign pos_nx  = mod_add(pos_q, dint_q, fsum[FRAC_W]);
	assign dint_nx = mod_add(dint_q, qint_q, dsum[FRAC_W]);
	assign d0      = {1'b0, cfg.linear_coeff} + {1'b0, cfg.quadratic_coeff};
	assign q2      = {cfg.quadratic_coeff, 1'b0};

	assign used_w = {1'b0, cnt_q} + (CW + 1)'(1);
	assign used_x = {{PROBES_W{1'b0}}, used_w};
	assign pos_x  = {{SLOT_W{1'b0}}, pos_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_addr  = pos_q;
		ram_wdata = {1'b0, key_q};
		pop       = 1'b0;
		start     = 1'b0;
		advance   = 1'b0;
		clearing  = 1'b0;
		unique case (state_q)
			B_CLEAR: begin
				clearing  = 1'b1;
				ram_we    = 1'b1;
				ram_addr  = clr_q;
				ram_wdata = EMPTY_WORD;
				if (clr_q == SLOT_LAST) begin
					state_d = B_IDLE;
				end
			end
			B_IDLE: begin
				ram_addr = pop_home;
				if (!q_empty) begin
					pop     = 1'b1;
					start   = 1'b1;
					ram_re  = 1'b1;
					state_d = B_CHECK;
				end
			end
			B_READ: begin
				ram_re  = 1'b1;
				state_d = B_CHECK;
			end
			B_CHECK: begin
				if (finish) begin
					if (out_free) begin
						ram_we  = empty_hit;
						state_d = B_IDLE;
					end
				end else begin
					advance = 1'b1;
					state_d = B_READ;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == B_CLEAR) begin
				clr_q <= clr_q + SW'(1);
			end
			if (state_q == B_CHECK && finish && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			key_q   <= pop_key;
			pos_q   <= pop_home;
			ffrac_q <= '0;
			dint_q  <= mod_small(d0[COEFF_W:FRAC_W]);
			dfrac_q <= d0[FRAC_W-1:0];
			qint_q  <= mod_small(q2[COEFF_W:FRAC_W]);
			qfrac_q <= q2[FRAC_W-1:0];
			cnt_q   <= '0;
		end
		if (advance) begin
			pos_q   <= pos_nx;
			ffrac_q <= fsum[FRAC_W-1:0];
			dint_q  <= dint_nx;
			dfrac_q <= dsum[FRAC_W-1:0];
			cnt_q   <= cnt_q + CW'(1);
		end
		if (state_q == B_CHECK && finish && out_free) begin
			inserted_q <= empty_hit;
			slot_q     <= pos_x[SLOT_W-1:0];
			probes_q   <= (used_x > (CW + PROBES_W + 1)'(PROBES_SAT)) ?
				PROBES_SAT : used_x[PROBES_W-1:0];
		end
	end

	assign out_valid   = out_valid_q;
	assign inserted    = inserted_q;
	assign slot        = slot_q;
	assign probes_used = probes_q;

endmodule

FILE: src/hash_insert_quadratic_probe.sv
// Hash table insert with quadratic probing.
// Input channel (in_valid/in_ready, key): one request per key to insert.
// Output channel (out_valid/out_ready): inserted, slot and probes_used,
// one result per key, in request order.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): always ready;
// index 0 hash multiplier, 1 hash shift, 2 linear coeff, 3 quadratic coeff,
// other indexes are dropped. Write only while the block is idle.
// The front end hashes a key (multiply, shift, stepwise remainder by SLOTS,
// hand-off) and parks it in a 2-entry queue; the back end walks the slot
// store through the single RAM port, each probe a read, then a check.
// The front end can hash the next key while the back end probes the last.
// After reset the store is swept to empty, with in_ready low.
// If out_ready stays low the finished result is held in the output
// register and the back end waits before writing the next key; the queue
// then fills and in_ready drops.
module hash_insert_quadratic_probe import hiqp_pkg::*; #(
	parameter int SLOTS      = 256,
	parameter int MAX_PROBES = 2560
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [KEY_W-1:0]      key,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  inserted,
	output logic [SLOT_W-1:0]     slot,
	output logic [PROBES_W-1:0]   probes_used,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CIDX_W-1:0]     cfg_index,
	input  logic [WORD_W-1:0]     cfg_data
);

	localparam int SW = $clog2(SLOTS);
	localparam int QW = KEY_W + SW;

	cfg_t cfg_q;

	logic          clearing;
	logic          q_push, q_pop, q_full, q_empty;
	logic [KEY_W-1:0] f_key;
	logic [SW-1:0]    f_home;
	logic [QW-1:0]    q_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hash_multiplier <= RST_HASH_MULT;
			cfg_q.hash_shift      <= RST_HASH_SHIFT;
			cfg_q.linear_coeff    <= RST_LIN_COEFF;
			cfg_q.quadratic_coeff <= RST_QUAD_COEFF;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_HASH_MULT:  cfg_q.hash_multiplier <= cfg_data;
				CFG_HASH_SHIFT: cfg_q.hash_shift      <= cfg_data[SHIFT_W-1:0];
				CFG_LIN_COEFF:  cfg_q.linear_coeff    <= cfg_data[COEFF_W-1:0];
				CFG_QUAD_COEFF: cfg_q.quadratic_coeff <= cfg_data[COEFF_W-1:0];
				default:        cfg_q <= cfg_q;
			endcase
		end
	end

	hiqp_front #(
		.SLOTS(SLOTS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.clearing (clearing),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.key      (key),
		.push     (q_push),
		.q_full   (q_full),
		.push_key (f_key),
		.push_home(f_home)
	);

	hiqp_fifo #(
		.WIDTH(QW),
		.DEPTH(2)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.wdata ({f_key, f_home}),
		.pop   (q_pop),
		.rdata (q_rdata),
		.full  (q_full),
		.empty (q_empty)
	);

	hiqp_back #(
		.SLOTS     (SLOTS),
		.MAX_PROBES(MAX_PROBES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.clearing   (clearing),
		.q_empty    (q_empty),
		.pop        (q_pop),
		.pop_key    (q_rdata[QW-1:SW]),
		.pop_home   (q_rdata[SW-1:0]),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.inserted   (inserted),
		.slot       (slot),
		.probes_used(probes_used)
	);

endmodule
